>>> hw/rtl/emp_pkg.sv
// Shared types and constants for the extent map page translator.
// Used by the translator top level, its table storage and its checker.
`default_nettype none

package emp_pkg;

    // Field widths of the stream payloads.
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;
    localparam int PAGE_W    = 32;
    localparam int BLK_W     = 32;
    localparam int VOL_W     = 16;
    localparam int IDX_W     = 10;
    localparam int S_DATA_W  = 112;
    localparam int M_DATA_W  = 64;
    localparam int M_PAD_W   = M_DATA_W - (BLK_W + VOL_W + IDX_W);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // Default sizing of the table and the page scale.
    localparam int MAX_ENTRIES_DEF     = 1024;
    localparam int BLOCKS_PER_PAGE_DEF = 16;

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Status codes carried in the output tuser.
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_SPARSE   = 3'd1;
    localparam logic [ST_W-1:0] ST_CLONE    = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd6;
    localparam logic [ST_W-1:0] ST_RESERVED = 3'd7;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PERM_HOLE  = 1'b1;
    localparam logic [BLK_W-1:0] TERMINATOR_RST = 32'hFFFF_FFFF;
    localparam logic [BLK_W-1:0] PERM_HOLE_RST  = 32'hFFFF_FFFE;

    // One extent as it is written into the table.
    typedef struct packed {
        logic [VOL_W-1:0]  vol;
        logic [BLK_W-1:0]  blk;
        logic [PAGE_W-1:0] page;
    } t_entry;

endpackage

`default_nettype wire

>>> hw/rtl/emp_table.sv
// Extent table storage: a start-page memory and a block/volume memory.
// Each has one write port and one registered read port. Uses emp_pkg.
`default_nettype none

module emp_table #(
    parameter int DEPTH = emp_pkg::MAX_ENTRIES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_we,
    input  wire  [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire  emp_pkg::t_entry            i_wentry,
    input  wire  [$clog2(DEPTH)-1:0]         i_page_raddr,
    output logic [emp_pkg::PAGE_W-1:0]       o_page_q,
    input  wire  [$clog2(DEPTH)-1:0]         i_blk_raddr,
    output logic [emp_pkg::BLK_W-1:0]        o_blk_q,
    output logic [emp_pkg::VOL_W-1:0]        o_vol_q
);
    import emp_pkg::*;

    logic [PAGE_W-1:0]       r_page_mem [DEPTH];
    logic [VOL_W+BLK_W-1:0]  r_bv_mem   [DEPTH];
    logic [VOL_W+BLK_W-1:0]  r_bv_q;

    // Start-page memory, scanned one entry per cycle during a lookup.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_page_mem[i_waddr] <= i_wentry.page;
        end
        o_page_q <= r_page_mem[i_page_raddr];
    end

    // Block and volume memory, read once for the matched entry.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_bv_mem[i_waddr] <= {i_wentry.vol, i_wentry.blk};
        end
        r_bv_q <= r_bv_mem[i_blk_raddr];
    end

    assign o_blk_q = r_bv_q[BLK_W-1:0];
    assign o_vol_q = r_bv_q[VOL_W+BLK_W-1:BLK_W];

endmodule

`default_nettype wire

>>> hw/rtl/extent_map_page_translate.sv
// Extent map page translator: top level with the control sequencer.
// Depends on emp_pkg and on emp_table for the extent storage.
//
// Usage: input transactions arrive on the i_s_* stream, one item each. tuser
// holds the operation (clear, append, look up); tdata holds the appended
// extent and the page to translate. Every item yields exactly one result on
// the o_m_* stream: tuser is the status, tdata the disk block, volume and
// matched entry index. Marker values are written on the i_cfg_* channel,
// which is always ready.
// Clear, append, unknown operations and a lookup on an empty table reach the
// output register through the result register. A lookup walks the
// start-page memory one entry per cycle, bound by its single read port: a
// translation then passes the fetch, evaluate and add states, a hole ends
// after evaluate and a page below every start page ends in the scan. The next
// item is accepted once the previous one is in the output register.
// Reset clears the entry count and the output valid and restores the marker
// defaults; the table memories are not cleared, only appended entries are used.
// When the receiver stalls, the finished result waits in the output
// register; one further item may be taken and computed, then the block holds
// its result and stops accepting until the output register frees up.
`default_nettype none

module extent_map_page_translate #(
    parameter int MAX_ENTRIES     = emp_pkg::MAX_ENTRIES_DEF,
    parameter int BLOCKS_PER_PAGE = emp_pkg::BLOCKS_PER_PAGE_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Input stream. tdata: entry_start_page, entry_block, entry_volume,
    // page_number (lowest bits first). tuser: operation.
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [emp_pkg::S_DATA_W-1:0]     i_s_tdata,
    input  wire  [emp_pkg::OP_W-1:0]         i_s_tuser,
    // Output stream. tdata: disk_block, volume, match_index, zero padding
    // (lowest bits first). tuser: status.
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [emp_pkg::M_DATA_W-1:0]     o_m_tdata,
    output logic [emp_pkg::ST_W-1:0]         o_m_tuser,
    // Configuration write channel.
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [emp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [emp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import emp_pkg::*;

    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int BW     = $clog2(BLOCKS_PER_PAGE + 1);
    localparam int PROD_W = PAGE_W + BW;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Control state.
    logic [2:0]        r_state,     n_state;
    logic [CW-1:0]     r_count,     n_count;
    logic              r_out_valid, n_out_valid;
    logic [BLK_W-1:0]  r_term,      n_term;
    logic [BLK_W-1:0]  r_phm,       n_phm;

    // Working payload.
    logic [AW-1:0]     r_idx,       n_idx;
    logic              r_prev_ge,   n_prev_ge;
    logic [PAGE_W-1:0] r_prev_sp,   n_prev_sp;
    logic [AW-1:0]     r_found,     n_found;
    logic [PAGE_W-1:0] r_found_sp,  n_found_sp;
    logic              r_last,      n_last;
    logic [PAGE_W-1:0] r_page,      n_page;
    logic [BLK_W-1:0]  r_blk,       n_blk;
    logic [VOL_W-1:0]  r_vol,       n_vol;
    logic [PROD_W-1:0] r_prod,      n_prod;
    logic [ST_W-1:0]   r_res_st,    n_res_st;
    logic [BLK_W-1:0]  r_res_blk,   n_res_blk;
    logic [VOL_W-1:0]  r_res_vol,   n_res_vol;
    logic [IDX_W-1:0]  r_res_idx,   n_res_idx;
    logic [ST_W-1:0]   r_out_st,    n_out_st;
    logic [BLK_W-1:0]  r_out_blk,   n_out_blk;
    logic [VOL_W-1:0]  r_out_vol,   n_out_vol;
    logic [IDX_W-1:0]  r_out_idx,   n_out_idx;

    // Table interface.
    logic              tbl_we;
    t_entry            tbl_wentry;
    logic [AW-1:0]     page_raddr;
    logic [PAGE_W-1:0] page_q;
    logic [BLK_W-1:0]  blk_q;
    logic [VOL_W-1:0]  vol_q;

    // Decoded input transaction.
    logic              in_fire;
    logic              tbl_full;
    logic [PAGE_W-1:0] in_start_page;
    logic [BLK_W-1:0]  in_block;
    logic [VOL_W-1:0]  in_volume;
    logic [PAGE_W-1:0] in_page;

    // Scan and translate datapath.
    logic              scan_ge;
    logic              scan_last;
    logic [PAGE_W-1:0] page_diff;
    logic [SUM_W-1:0]  blk_sum;

    assign in_start_page = i_s_tdata[PAGE_W-1:0];
    assign in_block      = i_s_tdata[PAGE_W+BLK_W-1:PAGE_W];
    assign in_volume     = i_s_tdata[PAGE_W+BLK_W+VOL_W-1:PAGE_W+BLK_W];
    assign in_page       = i_s_tdata[2*PAGE_W+BLK_W+VOL_W-1:PAGE_W+BLK_W+VOL_W];

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_s_tvalid && o_s_tready;
    assign tbl_full    = (r_count == CW'(MAX_ENTRIES));

    // Appends go straight into the table at the current fill count.
    assign tbl_we     = in_fire && (i_s_tuser == OP_APPEND) && !tbl_full;
    assign tbl_wentry = '{vol: in_volume, blk: in_block, page: in_start_page};

    // The scan reads the entry after the one being compared.
    assign page_raddr = (r_state == S_SCAN) ? AW'(r_idx + 1'b1) : '0;

    assign scan_ge   = (r_page >= page_q);
    assign scan_last = (CW'(r_idx) == CW'(r_count - 1'b1));
    assign page_diff = r_page - r_found_sp;
    assign blk_sum   = SUM_W'(r_blk) + SUM_W'(r_prod);

    emp_table #(
        .DEPTH (MAX_ENTRIES)
    ) u_emp_table (
        .i_clk        (i_clk),
        .i_we         (tbl_we),
        .i_waddr      (r_count[AW-1:0]),
        .i_wentry     (tbl_wentry),
        .i_page_raddr (page_raddr),
        .o_page_q     (page_q),
        .i_blk_raddr  (r_found),
        .o_blk_q      (blk_q),
        .o_vol_q      (vol_q)
    );

    // Sequencer: accept, scan, fetch the matched entry, translate, deliver.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_tready;
        n_term      = r_term;
        n_phm       = r_phm;
        n_idx       = r_idx;
        n_prev_ge   = r_prev_ge;
        n_prev_sp   = r_prev_sp;
        n_found     = r_found;
        n_found_sp  = r_found_sp;
        n_last      = r_last;
        n_page      = r_page;
        n_blk       = r_blk;
        n_vol       = r_vol;
        n_prod      = r_prod;
        n_res_st    = r_res_st;
        n_res_blk   = r_res_blk;
        n_res_vol   = r_res_vol;
        n_res_idx   = r_res_idx;
        n_out_st    = r_out_st;
        n_out_blk   = r_out_blk;
        n_out_vol   = r_out_vol;
        n_out_idx   = r_out_idx;

        // Configuration transactions.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TERMINATOR: n_term = i_cfg_data;
                REG_PERM_HOLE:  n_phm  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res_st  = ST_OK;
                    n_res_blk = '0;
                    n_res_vol = '0;
                    n_res_idx = '0;
                    n_state   = S_DONE;
                    case (i_s_tuser)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (tbl_full) begin
                                n_res_st = ST_FULL;
                            end else begin
                                n_res_idx = IDX_W'(r_count);
                                n_count   = CW'(r_count + 1'b1);
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_count == '0) begin
                                n_res_st = ST_EMPTY;
                            end else begin
                                n_page    = in_page;
                                n_idx     = '0;
                                n_prev_ge = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN: begin
                // The previous entry covers the page when the page lies
                // below this entry's start.
                if (r_prev_ge && !scan_ge) begin
                    n_found    = AW'(r_idx - 1'b1);
                    n_found_sp = r_prev_sp;
                    n_last     = 1'b0;
                    n_state    = S_FETCH;
                end else if (scan_last) begin
                    if (scan_ge) begin
                        n_found    = r_idx;
                        n_found_sp = page_q;
                        n_last     = 1'b1;
                        n_state    = S_FETCH;
                    end else begin
                        n_res_st  = ST_NOTFOUND;
                        n_res_blk = '0;
                        n_res_vol = '0;
                        n_res_idx = '0;
                        n_state   = S_DONE;
                    end
                end else begin
                    n_prev_ge = scan_ge;
                    n_prev_sp = page_q;
                    n_idx     = AW'(r_idx + 1'b1);
                end
            end

            S_FETCH: begin
                n_state = S_EVAL;
            end

            S_EVAL: begin
                n_res_blk = '0;
                n_res_vol = vol_q;
                n_res_idx = IDX_W'(r_found);
                n_state   = S_DONE;
                // A marker in the last entry covers no page at all.
                if (r_last && (blk_q == r_term || blk_q == r_phm)) begin
                    n_res_st  = ST_NOTFOUND;
                    n_res_vol = '0;
                    n_res_idx = '0;
                end else if (blk_q == r_phm || blk_q == '0) begin
                    n_res_st = ST_CLONE;
                end else if (blk_q == r_term) begin
                    n_res_st = ST_SPARSE;
                end else begin
                    n_blk   = blk_q;
                    n_vol   = vol_q;
                    n_prod  = PROD_W'(page_diff) * PROD_W'(BLOCKS_PER_PAGE);
                    n_state = S_ADD;
                end
            end

            S_ADD: begin
                n_res_vol = r_vol;
                n_res_idx = IDX_W'(r_found);
                if (blk_sum[SUM_W-1:BLK_W] != '0) begin
                    n_res_st  = ST_OVERFLOW;
                    n_res_blk = '0;
                end else begin
                    n_res_st  = ST_OK;
                    n_res_blk = blk_sum[BLK_W-1:0];
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                // Move the result into the output register once it is free.
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_blk   = r_res_blk;
                    n_out_vol   = r_res_vol;
                    n_out_idx   = r_res_idx;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_term      <= TERMINATOR_RST;
            r_phm       <= PERM_HOLE_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_term      <= n_term;
            r_phm       <= n_phm;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_prev_ge  <= n_prev_ge;
        r_prev_sp  <= n_prev_sp;
        r_found    <= n_found;
        r_found_sp <= n_found_sp;
        r_last     <= n_last;
        r_page     <= n_page;
        r_blk      <= n_blk;
        r_vol      <= n_vol;
        r_prod     <= n_prod;
        r_res_st   <= n_res_st;
        r_res_blk  <= n_res_blk;
        r_res_vol  <= n_res_vol;
        r_res_idx  <= n_res_idx;
        r_out_st   <= n_out_st;
        r_out_blk  <= n_out_blk;
        r_out_vol  <= n_out_vol;
        r_out_idx  <= n_out_idx;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_st;
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, r_out_idx, r_out_vol, r_out_blk};

endmodule

`default_nettype wire

>>> hw/rtl/emp_checker.sv
// Port-level checks on the result stream of the extent map page translator.
// Uses emp_pkg; attached to the top level by the bind at the end of the file.
`default_nettype none

module emp_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_m_tready,
    input wire                           o_m_tvalid,
    input wire [emp_pkg::M_DATA_W-1:0]   o_m_tdata,
    input wire [emp_pkg::ST_W-1:0]       o_m_tuser
);
    import emp_pkg::*;

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("result changed or dropped while stalled");

    // No result is offered in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // Only a successful translation carries a disk block.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_OK |-> o_m_tdata[BLK_W-1:0] == '0)
        else $error("disk block set on a failed translation");

    // Statuses without a matched entry carry an all-zero payload.
    a_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_EMPTY || o_m_tuser == ST_FULL
            || o_m_tuser == ST_NOTFOUND) |-> o_m_tdata == '0)
        else $error("payload set on a result without a match");

    // The unused status code never appears.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser != ST_RESERVED)
        else $error("reserved status code on the result stream");

endmodule

bind extent_map_page_translate emp_checker u_emp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the extent map page translator (extent_map_page_translate).
// Depends on emp_pkg for widths, operation and status codes and register indexes.
// It covers directed extremes, random map build-and-lookup runs, marker settings and a full table.
`default_nettype none

module tb;
    import emp_pkg::*;

    // There is no package constant for the unused operation code.
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
    localparam int PAGE_SCALE  = BLOCKS_PER_PAGE_DEF;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] start_page;
        logic [BLK_W-1:0]  block;
        logic [VOL_W-1:0]  volume;
        logic [PAGE_W-1:0] page_number;
    } t_request;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [BLK_W-1:0] phys_block;
        logic [VOL_W-1:0] volume;
        logic [IDX_W-1:0] index;
    } t_outcome;

    // One row of the directed stimulus; a fixed status means all other fields are zero.
    typedef struct {
        t_request        req;
        bit              has_fixed;
        logic [ST_W-1:0] fixed_status;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    wire                   o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata = '0;
    logic [OP_W-1:0]       i_s_tuser = '0;
    wire                   o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    wire  [M_DATA_W-1:0]   o_m_tdata;
    wire  [ST_W-1:0]       o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    wire                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    extent_map_page_translate i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a period of 12 time units.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit far above the slowest correct run.
    initial begin
        #12000000;
        $display("extent_map_page_translate test failed");
        $finish;
    end

    // Predicted copy of the extent table, the entry count and the markers.
    logic [PAGE_W-1:0] map_start_page [TABLE_DEPTH];
    logic [BLK_W-1:0]  map_block      [TABLE_DEPTH];
    logic [VOL_W-1:0]  map_volume     [TABLE_DEPTH];
    int                map_entries = 0;
    logic [BLK_W-1:0]  term_marker = TERMINATOR_RST;
    logic [BLK_W-1:0]  hole_marker = PERM_HOLE_RST;

    t_outcome pending_results [$];
    int       error_count = 0;
    int       items_sent = 0;
    int       pending_gap = 0;
    bit       s_valid_on = 1'b0;
    bit       send_no_idle = 1'b0;
    bit       recv_no_idle = 1'b0;
    int       long_hold = 0;
    t_row     directed_rows [$];

    // Computes the result of one accepted item and updates the predicted table.
    function automatic t_outcome translate_item(input t_request r);
        t_outcome         res;
        int               k;
        int               found;
        bit               hit;
        bit               done;
        logic [BLK_W-1:0] blk;
        logic [31:0]      offs;
        logic [63:0]      sum;
        res = '0;
        case (r.op)
            OP_CLEAR: begin
                map_entries = 0;
            end
            OP_APPEND: begin
                if (map_entries >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    map_start_page[map_entries] = r.start_page;
                    map_block[map_entries] = r.block;
                    map_volume[map_entries] = r.volume;
                    res.index = map_entries[IDX_W-1:0];
                    map_entries++;
                end
            end
            OP_LOOKUP: begin
                if (map_entries == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // Entry k covers pages up to the next start page; a marker as
                    // the last entry covers nothing, a mapped one runs without end.
                    hit = 1'b0;
                    done = 1'b0;
                    found = 0;
                    for (k = 0; k < map_entries && !done; k++) begin
                        if (r.page_number >= map_start_page[k]) begin
                            if (k + 1 < map_entries) begin
                                if (r.page_number < map_start_page[k + 1]) begin
                                    hit = 1'b1;
                                    found = k;
                                    done = 1'b1;
                                end
                            end else begin
                                if (map_block[k] != term_marker
                                        && map_block[k] != hole_marker) begin
                                    hit = 1'b1;
                                    found = k;
                                end
                                done = 1'b1;
                            end
                        end
                    end
                    if (!hit) begin
                        res.status = ST_NOTFOUND;
                    end else begin
                        blk = map_block[found];
                        res.volume = map_volume[found];
                        res.index = found[IDX_W-1:0];
                        // The clone hole test comes before the terminator test.
                        if (blk == hole_marker || blk == '0) begin
                            res.status = ST_CLONE;
                        end else if (blk == term_marker) begin
                            res.status = ST_SPARSE;
                        end else begin
                            offs = r.page_number - map_start_page[found];
                            sum = {32'd0, blk} + {32'd0, offs} * PAGE_SCALE;
                            if (sum[63:32] != '0) begin
                                res.status = ST_OVERFLOW;
                            end else begin
                                res.status = ST_OK;
                                res.phys_block = sum[31:0];
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_request make_request(input logic [OP_W-1:0] op,
                                              input logic [PAGE_W-1:0] sp,
                                              input logic [BLK_W-1:0] blk,
                                              input logic [VOL_W-1:0] vol,
                                              input logic [PAGE_W-1:0] pn);
        t_request r;
        r.op = op;
        r.start_page = sp;
        r.block = blk;
        r.volume = vol;
        r.page_number = pn;
        return r;
    endfunction

    // Block values lean toward zero, the markers and values near the top.
    function automatic logic [BLK_W-1:0] draw_block();
        logic [BLK_W-1:0] b;
        case ($urandom_range(0, 9))
            0: b = '0;
            1: b = term_marker;
            2: b = hole_marker;
            3: b = 32'hFFFF_FFFF - $urandom_range(0, 64);
            default: b = $urandom;
        endcase
        return b;
    endfunction

    // Lookup pages mostly land in or next to stored extents.
    function automatic logic [PAGE_W-1:0] draw_lookup_page();
        logic [PAGE_W-1:0] p;
        int                k;
        if (map_entries == 0) begin
            return $urandom;
        end
        k = $urandom_range(0, map_entries - 1);
        case ($urandom_range(0, 9))
            0: p = map_start_page[k] - 1;
            1: p = map_start_page[k];
            2: p = $urandom;
            3: p = 32'hFFFF_FFFF;
            default: p = map_start_page[k] + $urandom_range(0, 40);
        endcase
        return p;
    endfunction

    // Offers one item and records its expected result when it is accepted.
    task automatic send_item(input t_request r, input bit has_fixed,
                             input logic [ST_W-1:0] fixed_status);
        t_outcome predicted;
        repeat (pending_gap) @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        s_valid_on = 1'b1;
        i_s_tdata <= {r.page_number, r.volume, r.block, r.start_page};
        i_s_tuser <= r.op;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = translate_item(r);
        if (has_fixed) begin
            predicted = '0;
            predicted.status = fixed_status;
        end
        pending_results.push_back(predicted);
        items_sent++;
        // Valid stays high only when the next item follows without a gap.
        pending_gap = send_no_idle ? 0 : $urandom_range(0, 8);
        if (pending_gap > 0) begin
            i_s_tvalid <= 1'b0;
            s_valid_on = 1'b0;
        end
    endtask

    task automatic offer(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] sp,
                         input logic [BLK_W-1:0] blk, input logic [VOL_W-1:0] vol,
                         input logic [PAGE_W-1:0] pn);
        send_item(make_request(op, sp, blk, vol, pn), 1'b0, ST_OK);
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] sp,
                           input logic [BLK_W-1:0] blk, input logic [VOL_W-1:0] vol,
                           input logic [PAGE_W-1:0] pn, input bit has_fixed,
                           input logic [ST_W-1:0] fixed_status);
        t_row row;
        row.req = make_request(op, sp, blk, vol, pn);
        row.has_fixed = has_fixed;
        row.fixed_status = fixed_status;
        directed_rows.push_back(row);
    endtask

    task automatic stop_input();
        if (s_valid_on) begin
            i_s_tvalid <= 1'b0;
            s_valid_on = 1'b0;
        end
        @(posedge i_clk);
    endtask

    // Holds the input until every expected result has come back.
    task automatic drain();
        stop_input();
        wait (pending_results.size() == 0);
        @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_TERMINATOR) begin
            term_marker = value;
        end else begin
            hole_marker = value;
        end
    endtask

    // Optional clear, a run of appends with non-decreasing pages (sometimes unsorted), then lookups.
    task automatic map_scenario();
        int                n_app;
        int                n_look;
        int                k;
        bit                unsorted;
        logic [PAGE_W-1:0] pg;
        logic [PAGE_W:0]   nxt;
        if ($urandom_range(0, 4) != 0) begin
            offer(OP_CLEAR, $urandom, $urandom, VOL_W'($urandom), $urandom);
        end
        n_app = $urandom_range(1, 12);
        unsorted = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0: pg = '0;
            1: pg = 32'hFFFF_FF80;
            default: pg = $urandom;
        endcase
        for (k = 0; k < n_app; k++) begin
            offer(OP_APPEND, pg, draw_block(), VOL_W'($urandom), $urandom);
            nxt = {1'b0, pg} + $urandom_range(0, 48);
            pg = unsorted ? $urandom : (nxt[PAGE_W] ? 32'hFFFF_FFFF : nxt[PAGE_W-1:0]);
        end
        n_look = $urandom_range(2, 10);
        for (k = 0; k < n_look; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                offer(OP_NONE, $urandom, $urandom, VOL_W'($urandom), $urandom);
            end
            offer(OP_LOOKUP, $urandom, $urandom, VOL_W'($urandom), draw_lookup_page());
        end
    endtask

    task automatic random_step();
        if ($urandom_range(0, 24) == 0) begin
            drain();
        end
        if ($urandom_range(0, 3) == 0) begin
            offer(OP_W'($urandom_range(0, 3)), $urandom, $urandom, VOL_W'($urandom),
                  $urandom);
        end else begin
            map_scenario();
        end
    endtask

    // Result side: random stalls, then each result is checked against the oldest expectation.
    initial begin
        t_outcome got;
        t_outcome want;
        int       stall;
        bit       m_ready_on;
        m_ready_on = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold > 0) begin
                stall = long_hold;
                long_hold = 0;
            end else begin
                stall = recv_no_idle ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                if (m_ready_on) begin
                    i_m_tready <= 1'b0;
                    m_ready_on = 1'b0;
                end
                repeat (stall) @(posedge i_clk);
            end
            if (!m_ready_on) begin
                i_m_tready <= 1'b1;
                m_ready_on = 1'b1;
            end
            do @(posedge i_clk); while (!o_m_tvalid);
            got.status = o_m_tuser;
            got.phys_block = o_m_tdata[BLK_W-1:0];
            got.volume = o_m_tdata[BLK_W +: VOL_W];
            got.index = o_m_tdata[BLK_W + VOL_W +: IDX_W];
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: status %0d", got.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.phys_block !== want.phys_block) begin
                    $error("phys_block: expected %h, got %h", want.phys_block,
                           got.phys_block);
                    error_count++;
                end
                if (got.volume !== want.volume) begin
                    $error("volume: expected %h, got %h", want.volume, got.volume);
                    error_count++;
                end
                if (got.index !== want.index) begin
                    $error("match_index: expected %0d, got %0d", want.index, got.index);
                    error_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed rows, random phases over marker settings, full table.
    initial begin
        int               k;
        int               phase;
        int               target;
        logic [BLK_W-1:0] marker;
        logic [PAGE_W-1:0] pg;

        // Directed rows under the reset marker values.
        add_row(OP_LOOKUP, '0, '0, '0, 32'h0000_0005, 1'b1, ST_EMPTY);
        add_row(OP_NONE, '1, '1, '1, '1, 1'b1, ST_OK);
        add_row(OP_APPEND, 32'd0, 32'd100, 16'hFFFF, '0, 1'b0, ST_OK);
        add_row(OP_APPEND, 32'd10, 32'd0, 16'd1, '0, 1'b0, ST_OK);
        add_row(OP_APPEND, 32'd20, PERM_HOLE_RST, 16'd2, '0, 1'b0, ST_OK);
        add_row(OP_APPEND, 32'd30, TERMINATOR_RST, 16'd3, '0, 1'b0, ST_OK);
        add_row(OP_APPEND, 32'd40, 32'hFFFF_FFF0, 16'd4, '0, 1'b0, ST_OK);
        add_row(OP_APPEND, 32'h1000_0000, 32'd5, 16'd0, '0, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd0, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd9, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd15, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd25, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd35, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd40, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd41, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'hFFFF_FFFF, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'h1000_0001, 1'b0, ST_OK);
        add_row(OP_CLEAR, '1, '1, '1, '1, 1'b1, ST_OK);
        add_row(OP_APPEND, 32'd50, 32'd7, 16'd9, '0, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd49, 1'b0, ST_OK);
        add_row(OP_APPEND, 32'd60, TERMINATOR_RST, 16'd8, '0, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd70, 1'b0, ST_OK);
        add_row(OP_LOOKUP, '0, '0, '0, 32'd55, 1'b0, ST_OK);
        add_row(OP_NONE, '0, '0, '0, '0, 1'b1, ST_OK);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].req, directed_rows[k].has_fixed,
                      directed_rows[k].fixed_status);
        end

        // Random phases, each under its own marker setting.
        for (phase = 1; phase <= 5; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_TERMINATOR, 32'h0000_0000);
                    write_reg(REG_PERM_HOLE, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(REG_TERMINATOR, 32'hFFFF_FFFF);
                    write_reg(REG_PERM_HOLE, 32'h0000_0000);
                end
                3: begin
                    write_reg(REG_TERMINATOR, $urandom);
                    write_reg(REG_PERM_HOLE, $urandom);
                end
                4: begin
                    // Both markers equal: the clone hole check wins.
                    marker = $urandom;
                    write_reg(REG_TERMINATOR, marker);
                    write_reg(REG_PERM_HOLE, marker);
                end
                default: begin
                    write_reg(REG_TERMINATOR, TERMINATOR_RST);
                    write_reg(REG_PERM_HOLE, PERM_HOLE_RST);
                end
            endcase
            send_no_idle = (phase == 4);
            recv_no_idle = (phase == 4);
            if (phase == 3) begin
                // Long result hold-off while the input keeps offering items.
                long_hold = 200;
                send_no_idle = 1'b1;
                map_scenario();
                map_scenario();
                send_no_idle = 1'b0;
            end
            target = items_sent + 90;
            while (items_sent < target) begin
                random_step();
            end
        end
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;

        // Fill the table completely, then overflow it and scan it end to end.
        offer(OP_CLEAR, '0, '0, '0, '0);
        pg = $urandom_range(0, 1000);
        for (k = 0; k < TABLE_DEPTH; k++) begin
            offer(OP_APPEND, pg, $urandom_range(1, 32'h7FFF_FFFF), VOL_W'($urandom),
                  $urandom);
            pg = pg + $urandom_range(1, 3);
        end
        send_item(make_request(OP_APPEND, $urandom, $urandom, VOL_W'($urandom), $urandom),
                  1'b1, ST_FULL);
        send_item(make_request(OP_APPEND, '1, '1, '1, '1), 1'b1, ST_FULL);
        offer(OP_LOOKUP, '0, '0, '0, map_start_page[TABLE_DEPTH-1] + 3);
        offer(OP_LOOKUP, '0, '0, '0, map_start_page[0]);
        offer(OP_LOOKUP, '0, '0, '0, map_start_page[TABLE_DEPTH/2]);
        for (k = 0; k < 3; k++) begin
            offer(OP_LOOKUP, '0, '0, '0, draw_lookup_page());
        end
        send_item(make_request(OP_CLEAR, '0, '0, '0, '0), 1'b1, ST_OK);
        send_item(make_request(OP_LOOKUP, '0, '0, '0, $urandom), 1'b1, ST_EMPTY);

        stop_input();
        wait (pending_results.size() == 0);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("extent_map_page_translate test passed");
        end else begin
            $display("extent_map_page_translate test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
